// ----- rtl/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, sizes and codes shared by the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int FRAME_WORDS   = 16;
	localparam int FRAME_TOTAL   = 16;
	localparam int MEMORY_WORDS  = 256;
	localparam int TABLE_ENTRIES = 64;

	localparam int WORD_AW  = 8;   // word_owner address
	localparam int OFS_W    = 4;   // word within a frame
	localparam int FRAME_W  = 4;   // frame number
	localparam int ENT_AW   = 6;   // table entry index
	localparam int FRM_AW   = ENT_AW + FRAME_W;
	localparam int TOTAL_W  = 7;   // entry count, 0..TABLE_ENTRIES
	localparam int COUNT_W  = 5;   // frames in an entry, 0..FRAME_TOTAL
	localparam int NEED_W   = 9;   // ceil(request_size / FRAME_WORDS)
	localparam int TAG_W    = 8;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_BADIDX  = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  process_id;
		logic [11:0] request_size;
		logic [5:0]  entry_index;
		logic [3:0]  frame_slot;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] owner_id;
		logic [3:0] frame_number;
		logic [4:0] frame_count;
		logic       last;
	} resp_t;

	typedef struct packed {
		logic [TAG_W-1:0]   owner;
		logic [COUNT_W-1:0] count;
	} entry_t;

endpackage

// ----- rtl/paged_frame_allocator_core.sv -----
// ----------------------------------------------------------------------------
// paged_frame_allocator_core
// First-fit frame allocator with an owner tag per word and a page table.
//
//   channel  | handshake           | word
//   ---------+---------------------+------------------------
//   request  | in_valid / in_ready | in_data  (pfa_pkg::req_t)
//   result   | out_valid/out_ready | out_data (pfa_pkg::resp_t)
//
// One request at a time. Allocate scans each frame word by word and then
// claims a free frame word by word; a failed allocate and every free add an
// owner sweep of the word memory, and free also searches the table entries
// and shifts later entries down. All of it is set by the one read and one
// write port of each memory. After reset a pass clears the word memory
// before the first request is taken. A stalled result holds the engine
// only when the next result is ready to load.
// ----------------------------------------------------------------------------
module paged_frame_allocator_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pfa_pkg::req_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output pfa_pkg::resp_t  out_data
);

	typedef enum logic [10:0] {
		S_INIT   = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_ASCAN  = 11'b00000000100,
		S_ACHK   = 11'b00000001000,
		S_ACLAIM = 11'b00000010000,
		S_CLR    = 11'b00000100000,
		S_FSRCH  = 11'b00001000000,
		S_FSCHK  = 11'b00010000000,
		S_FSHIFT = 11'b00100000000,
		S_RDCHK  = 11'b01000000000,
		S_OUT    = 11'b10000000000
	} state_t;

	state_t state_q;

	// memories
	logic [pfa_pkg::TAG_W-1:0]   word_mem [pfa_pkg::MEMORY_WORDS];
	pfa_pkg::entry_t             ent_mem  [pfa_pkg::TABLE_ENTRIES];
	logic [pfa_pkg::FRAME_W-1:0] frm_mem  [pfa_pkg::TABLE_ENTRIES * pfa_pkg::FRAME_TOTAL];

	logic                        word_re, word_we;
	logic [pfa_pkg::WORD_AW-1:0] word_raddr, word_waddr;
	logic [pfa_pkg::TAG_W-1:0]   word_wdata, word_rd_q;

	logic                        ent_re, ent_we;
	logic [pfa_pkg::ENT_AW-1:0]  ent_raddr, ent_waddr;
	pfa_pkg::entry_t             ent_wdata, ent_rd_q;

	logic                        frm_re, frm_we;
	logic [pfa_pkg::FRM_AW-1:0]  frm_raddr, frm_waddr;
	logic [pfa_pkg::FRAME_W-1:0] frm_wdata, frm_rd_q;

	// control and working registers
	logic [1:0]                   op_q;
	logic [pfa_pkg::TAG_W-1:0]    tag_q;
	logic [pfa_pkg::NEED_W-1:0]   need_q;
	logic [pfa_pkg::ENT_AW-1:0]   idx_q;
	logic [pfa_pkg::FRAME_W-1:0]  slot_q;
	logic [pfa_pkg::TOTAL_W-1:0]  total_q;
	logic [pfa_pkg::FRAME_W:0]    f_q;
	logic [9:0]                   ctr_q;
	logic [pfa_pkg::COUNT_W-1:0]  count_q;
	logic                         busy_q;
	logic [pfa_pkg::FRAME_W-1:0]  got_q [pfa_pkg::FRAME_TOTAL];
	logic [pfa_pkg::COUNT_W-1:0]  removed_q;
	logic [pfa_pkg::FRM_AW-1:0]   p_q;
	logic                         multi_q;
	logic [pfa_pkg::FRAME_W-1:0]  e_q;
	pfa_pkg::resp_t               res_q;
	pfa_pkg::resp_t               out_q;
	logic                         out_valid_q;

	// pipeline stage of the sweeps
	logic                         scan_v_s1;
	logic                         clr_v_s1;
	logic [pfa_pkg::WORD_AW-1:0]  clr_a_s1;
	logic                         sh_v_s1;
	logic                         sh_e_s1;
	logic [pfa_pkg::FRM_AW-1:0]   sh_p_s1;

	logic                         accept;
	logic                         out_free;
	logic                         frame_busy;
	logic                         claim_done;
	logic                         alloc_ok;
	logic                         clr_issue;
	logic                         sh_issue;
	logic [pfa_pkg::FRM_AW-1:0]   sh_end;
	logic [pfa_pkg::NEED_W-1:0]   in_need;
	logic [pfa_pkg::WORD_AW-1:0]  frame_addr;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign in_need    = pfa_pkg::NEED_W'((13'(in_data.request_size) +
	                    13'(pfa_pkg::FRAME_WORDS - 1)) >> pfa_pkg::OFS_W);
	assign frame_addr = {f_q[pfa_pkg::FRAME_W-1:0], ctr_q[pfa_pkg::OFS_W-1:0]};
	assign frame_busy = busy_q || (word_rd_q != '0);
	assign claim_done = (state_q == S_ACLAIM) && (ctr_q[pfa_pkg::OFS_W-1:0] == '1);
	assign alloc_ok   = claim_done &&
	                    (pfa_pkg::NEED_W'(count_q) + pfa_pkg::NEED_W'(1) == need_q);
	assign clr_issue  = (state_q == S_CLR) && !ctr_q[pfa_pkg::WORD_AW];
	assign sh_end     = {total_q[pfa_pkg::ENT_AW-1:0] - pfa_pkg::ENT_AW'(1),
	                     {pfa_pkg::FRAME_W{1'b0}}};
	assign sh_issue   = (state_q == S_FSHIFT) && (p_q != sh_end);

	// memory port steering
	always_comb begin
		word_re    = 1'b0;
		word_raddr = ctr_q[pfa_pkg::WORD_AW-1:0];
		word_we    = 1'b0;
		word_waddr = ctr_q[pfa_pkg::WORD_AW-1:0];
		word_wdata = '0;
		unique case (1'b1)
			state_q[0]: word_we = 1'b1;
			state_q[2]: begin
				word_re    = 1'b1;
				word_raddr = frame_addr;
			end
			state_q[4]: begin
				word_we    = 1'b1;
				word_waddr = frame_addr;
				word_wdata = tag_q;
			end
			default: ;
		endcase
		if (clr_issue) begin
			word_re = 1'b1;
		end
		if (clr_v_s1 && word_rd_q == tag_q) begin
			word_we    = 1'b1;
			word_waddr = clr_a_s1;
			word_wdata = '0;
		end
	end

	always_comb begin
		ent_re    = 1'b0;
		ent_raddr = ctr_q[pfa_pkg::ENT_AW-1:0];
		ent_we    = 1'b0;
		ent_waddr = total_q[pfa_pkg::ENT_AW-1:0];
		ent_wdata = '{owner: tag_q, count: count_q + pfa_pkg::COUNT_W'(1)};
		frm_re    = 1'b0;
		frm_raddr = {in_data.entry_index, in_data.frame_slot};
		frm_we    = 1'b0;
		frm_waddr = {total_q[pfa_pkg::ENT_AW-1:0], count_q[pfa_pkg::FRAME_W-1:0]};
		frm_wdata = f_q[pfa_pkg::FRAME_W-1:0];
		if (accept && in_data.operation == pfa_pkg::OP_READ) begin
			ent_re    = 1'b1;
			ent_raddr = in_data.entry_index;
			frm_re    = 1'b1;
		end
		if (state_q == S_FSRCH) begin
			ent_re = 1'b1;
		end
		if (alloc_ok) begin
			ent_we = 1'b1;
		end
		if ((state_q == S_ACLAIM) && ctr_q[pfa_pkg::OFS_W-1:0] == '0) begin
			frm_we = 1'b1;
		end
		// shift down: read one row ahead, write it into the row below on the next cycle
		if (sh_issue) begin
			frm_re    = 1'b1;
			frm_raddr = p_q + pfa_pkg::FRM_AW'(pfa_pkg::FRAME_TOTAL);
			if (p_q[pfa_pkg::FRAME_W-1:0] == '0) begin
				ent_re    = 1'b1;
				ent_raddr = p_q[pfa_pkg::FRM_AW-1:pfa_pkg::FRAME_W] + pfa_pkg::ENT_AW'(1);
			end
		end
		if (sh_v_s1) begin
			frm_we    = 1'b1;
			frm_waddr = sh_p_s1;
			frm_wdata = frm_rd_q;
		end
		if (sh_e_s1) begin
			ent_we    = 1'b1;
			ent_waddr = sh_p_s1[pfa_pkg::FRM_AW-1:pfa_pkg::FRAME_W];
			ent_wdata = ent_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (word_we) begin
			word_mem[word_waddr] <= word_wdata;
		end
		if (word_re) begin
			word_rd_q <= word_mem[word_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		if (ent_re) begin
			ent_rd_q <= ent_mem[ent_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (frm_we) begin
			frm_mem[frm_waddr] <= frm_wdata;
		end
		if (frm_re) begin
			frm_rd_q <= frm_mem[frm_raddr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_data.operation;
			tag_q  <= in_data.process_id;
			need_q <= in_need;
			idx_q  <= in_data.entry_index;
			slot_q <= in_data.frame_slot;
		end
		if ((state_q == S_ACLAIM) && ctr_q[pfa_pkg::OFS_W-1:0] == '0) begin
			got_q[count_q[pfa_pkg::FRAME_W-1:0]] <= f_q[pfa_pkg::FRAME_W-1:0];
		end
		clr_a_s1 <= ctr_q[pfa_pkg::WORD_AW-1:0];
		sh_p_s1  <= p_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			total_q     <= '0;
			ctr_q       <= '0;
			f_q         <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			removed_q   <= '0;
			p_q         <= '0;
			multi_q     <= 1'b0;
			e_q         <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			scan_v_s1   <= 1'b0;
			clr_v_s1    <= 1'b0;
			sh_v_s1     <= 1'b0;
			sh_e_s1     <= 1'b0;
		end else begin
			scan_v_s1 <= (state_q == S_ASCAN);
			clr_v_s1  <= clr_issue;
			sh_v_s1   <= sh_issue;
			sh_e_s1   <= sh_issue && (p_q[pfa_pkg::FRAME_W-1:0] == '0);
			// the result state reloads the output word itself
			if (out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_INIT: begin
					ctr_q <= ctr_q + 10'd1;
					if (ctr_q[pfa_pkg::WORD_AW-1:0] == '1) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					ctr_q   <= '0;
					f_q     <= '0;
					count_q <= '0;
					multi_q <= 1'b0;
					e_q     <= '0;
					if (accept) begin
						case (in_data.operation)
							pfa_pkg::OP_ALLOC: begin
								if (total_q >= pfa_pkg::TOTAL_W'(pfa_pkg::TABLE_ENTRIES)) begin
									res_q   <= '{pfa_pkg::ST_FULL, in_data.process_id,
									             4'd0, 5'd0, 1'b1};
									state_q <= S_OUT;
								end else if (in_need == '0) begin
									res_q   <= '{pfa_pkg::ST_NOSPACE, in_data.process_id,
									             4'd0, 5'd0, 1'b1};
									state_q <= S_CLR;
								end else begin
									state_q <= S_ASCAN;
								end
							end
							pfa_pkg::OP_FREE:  state_q <= S_CLR;
							pfa_pkg::OP_READ:  state_q <= S_RDCHK;
							default: ;
						endcase
					end
				end

				S_ASCAN: begin
					busy_q <= (ctr_q[pfa_pkg::OFS_W-1:0] == '0) ? 1'b0 :
					          (busy_q || (scan_v_s1 && word_rd_q != '0));
					ctr_q  <= ctr_q + 10'd1;
					if (ctr_q[pfa_pkg::OFS_W-1:0] == '1) begin
						state_q <= S_ACHK;
					end
				end

				S_ACHK: begin
					ctr_q <= '0;
					if (!frame_busy) begin
						state_q <= S_ACLAIM;
					end else begin
						f_q <= f_q + 1'b1;
						if (f_q == 5'(pfa_pkg::FRAME_TOTAL - 1)) begin
							res_q   <= '{pfa_pkg::ST_NOSPACE, tag_q, 4'd0, 5'd0, 1'b1};
							state_q <= S_CLR;
						end else begin
							state_q <= S_ASCAN;
						end
					end
				end

				S_ACLAIM: begin
					if (claim_done) begin
						ctr_q   <= '0;
						count_q <= count_q + pfa_pkg::COUNT_W'(1);
						f_q     <= f_q + 1'b1;
						if (alloc_ok) begin
							total_q <= total_q + pfa_pkg::TOTAL_W'(1);
							multi_q <= 1'b1;
							state_q <= S_OUT;
						end else if (f_q == 5'(pfa_pkg::FRAME_TOTAL - 1)) begin
							res_q   <= '{pfa_pkg::ST_NOSPACE, tag_q, 4'd0, 5'd0, 1'b1};
							state_q <= S_CLR;
						end else begin
							state_q <= S_ASCAN;
						end
					end else begin
						ctr_q <= ctr_q + 10'd1;
					end
				end

				S_CLR: begin
					if (clr_issue) begin
						ctr_q <= ctr_q + 10'd1;
					end else if (!clr_v_s1) begin
						ctr_q <= '0;
						state_q <= (op_q == pfa_pkg::OP_FREE) ? S_FSRCH : S_OUT;
					end
				end

				S_FSRCH: begin
					if (ctr_q[pfa_pkg::TOTAL_W-1:0] >= total_q) begin
						res_q   <= '{pfa_pkg::ST_OK, tag_q, 4'd0, 5'd0, 1'b1};
						state_q <= S_OUT;
					end else begin
						state_q <= S_FSCHK;
					end
				end

				S_FSCHK: begin
					if (ent_rd_q.owner == tag_q) begin
						removed_q <= ent_rd_q.count;
						p_q       <= {ctr_q[pfa_pkg::ENT_AW-1:0], {pfa_pkg::FRAME_W{1'b0}}};
						state_q   <= S_FSHIFT;
					end else begin
						ctr_q   <= ctr_q + 10'd1;
						state_q <= S_FSRCH;
					end
				end

				S_FSHIFT: begin
					if (sh_issue) begin
						p_q <= p_q + pfa_pkg::FRM_AW'(1);
					end else if (!sh_v_s1) begin
						total_q <= total_q - pfa_pkg::TOTAL_W'(1);
						res_q   <= '{pfa_pkg::ST_OK, tag_q, 4'd0, removed_q, 1'b1};
						state_q <= S_OUT;
					end
				end

				S_RDCHK: begin
					if ({1'b0, idx_q} >= total_q) begin
						res_q <= '{pfa_pkg::ST_BADIDX, 8'd0, 4'd0, 5'd0, 1'b1};
					end else if ({1'b0, slot_q} >= ent_rd_q.count) begin
						res_q <= '{pfa_pkg::ST_BADIDX, ent_rd_q.owner, 4'd0,
						           ent_rd_q.count, 1'b1};
					end else begin
						res_q <= '{pfa_pkg::ST_OK, ent_rd_q.owner, frm_rd_q,
						           ent_rd_q.count, 1'b1};
					end
					state_q <= S_OUT;
				end

				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (multi_q) begin
							out_q <= '{pfa_pkg::ST_OK, tag_q, got_q[e_q], count_q,
							           (pfa_pkg::COUNT_W'(e_q) + pfa_pkg::COUNT_W'(1)
							            == count_q)};
							e_q   <= e_q + pfa_pkg::FRAME_W'(1);
							if (pfa_pkg::COUNT_W'(e_q) + pfa_pkg::COUNT_W'(1) == count_q) begin
								state_q <= S_IDLE;
							end
						end else begin
							out_q   <= res_q;
							state_q <= S_IDLE;
						end
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sim/pfa_checker.sv -----
// ----------------------------------------------------------------------------
// pfa_checker
// Watches both channels of the frame allocator, keeps a shadow of its word
// owners and page table, and compares every result word with the prediction.
// ----------------------------------------------------------------------------
module pfa_checker
	import pfa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_ready,
	input  req_t  in_data,
	input  logic  out_valid,
	input  logic  out_ready,
	input  resp_t out_data,
	output int    fail_count,
	output int    pending_results,
	output int    results_checked
);

	logic [TAG_W-1:0]   word_tag [MEMORY_WORDS];
	logic [TAG_W-1:0]   tbl_owner [TABLE_ENTRIES];
	logic [COUNT_W-1:0] tbl_count [TABLE_ENTRIES];
	logic [FRAME_W-1:0] tbl_frame [TABLE_ENTRIES][FRAME_TOTAL];
	int                 tbl_used;
	resp_t              expected_words[$];
	int                 fails;
	int                 checked;

	assign fail_count      = fails;
	assign pending_results = expected_words.size();
	assign results_checked = checked;

	initial begin
		foreach (word_tag[i]) word_tag[i] = '0;
		tbl_used = 0;
		fails    = 0;
		checked  = 0;
	end

	function automatic resp_t make_word(logic [1:0] st, logic [7:0] own, logic [3:0] frm,
			logic [4:0] cnt, logic lst);
		resp_t w;
		w.status       = st;
		w.owner_id     = own;
		w.frame_number = frm;
		w.frame_count  = cnt;
		w.last         = lst;
		return w;
	endfunction

	function automatic bit frame_is_free(int f);
		int start;
		start = f * FRAME_WORDS;
		for (int i = 0; i < FRAME_WORDS; i++) begin
			if (start + i >= MEMORY_WORDS || word_tag[start + i] != '0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic sweep_owner(logic [7:0] tag);
		foreach (word_tag[i]) begin
			if (word_tag[i] == tag)
				word_tag[i] = '0;
		end
	endtask

	task automatic predict_allocate(logic [7:0] tag, logic [11:0] size);
		int need;
		int got;
		logic [3:0] claimed [FRAME_TOTAL];
		need = (int'(size) + FRAME_WORDS - 1) / FRAME_WORDS;
		got  = 0;
		if (tbl_used >= TABLE_ENTRIES) begin
			expected_words.push_back(make_word(ST_FULL, tag, '0, '0, 1'b1));
			return;
		end
		for (int f = 0; f < FRAME_TOTAL && got != need; f++) begin
			if (frame_is_free(f)) begin
				for (int i = 0; i < FRAME_WORDS; i++)
					word_tag[f * FRAME_WORDS + i] = tag;
				claimed[got] = f[3:0];
				got++;
			end
		end
		if (need == 0 || got != need) begin
			// roll back everything this process holds
			sweep_owner(tag);
			expected_words.push_back(make_word(ST_NOSPACE, tag, '0, '0, 1'b1));
			return;
		end
		tbl_owner[tbl_used] = tag;
		tbl_count[tbl_used] = got[4:0];
		for (int i = 0; i < got; i++) begin
			tbl_frame[tbl_used][i] = claimed[i];
			expected_words.push_back(make_word(ST_OK, tag, claimed[i], got[4:0],
				i + 1 == got));
		end
		tbl_used++;
	endtask

	task automatic predict_free(logic [7:0] tag);
		logic [4:0] removed;
		removed = '0;
		sweep_owner(tag);
		for (int i = 0; i < tbl_used; i++) begin
			if (tbl_owner[i] == tag) begin
				removed = tbl_count[i];
				// shift later entries down over the removed one
				for (int j = i; j + 1 < tbl_used; j++) begin
					tbl_owner[j] = tbl_owner[j + 1];
					tbl_count[j] = tbl_count[j + 1];
					tbl_frame[j] = tbl_frame[j + 1];
				end
				tbl_used--;
				break;
			end
		end
		expected_words.push_back(make_word(ST_OK, tag, '0, removed, 1'b1));
	endtask

	task automatic predict_read(logic [5:0] idx, logic [3:0] slot);
		if (int'(idx) >= tbl_used) begin
			expected_words.push_back(make_word(ST_BADIDX, '0, '0, '0, 1'b1));
		end else if (slot >= tbl_count[idx]) begin
			expected_words.push_back(make_word(ST_BADIDX, tbl_owner[idx], '0,
				tbl_count[idx], 1'b1));
		end else begin
			expected_words.push_back(make_word(ST_OK, tbl_owner[idx],
				tbl_frame[idx][slot], tbl_count[idx], 1'b1));
		end
	endtask

	always @(posedge clk) begin
		resp_t want;
		if (arst_n && in_valid && in_ready) begin
			case (in_data.operation)
				OP_ALLOC: predict_allocate(in_data.process_id, in_data.request_size);
				OP_FREE:  predict_free(in_data.process_id);
				OP_READ:  predict_read(in_data.entry_index, in_data.frame_slot);
				default: ;  // unused code, drop
			endcase
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result word %p", out_data);
			end else begin
				want = expected_words.pop_front();
				checked++;
				if (out_data !== want) begin
					fails++;
					if (fails <= 10)
						$display("mismatch: status %0d/%0d owner %0d/%0d frame %0d/%0d count %0d/%0d last %0d/%0d (exp/got)",
							want.status, out_data.status, want.owner_id, out_data.owner_id,
							want.frame_number, out_data.frame_number,
							want.frame_count, out_data.frame_count,
							want.last, out_data.last);
				end
			end
		end
	end

endmodule

// ----- sim/paged_frame_allocator_core_tb.sv -----
// ----------------------------------------------------------------------------
// paged_frame_allocator_core_tb
// Drives allocate, free and read requests into the frame allocator with
// bursty input and a stalling receiver; pfa_checker predicts and compares.
// ----------------------------------------------------------------------------
module paged_frame_allocator_core_tb;

	// operation code the block ignores
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           in_valid  = 1'b0;
	pfa_pkg::req_t  in_data   = '0;
	logic           out_ready = 1'b0;
	logic           in_ready;
	logic           out_valid;
	pfa_pkg::resp_t out_data;

	int fail_count;
	int pending_results;
	int results_checked;
	int words_sent     = 0;
	int burst_left     = 0;
	int holds_asked    = 0;
	int holds_done     = 0;
	int full_seq_done  = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	paged_frame_allocator_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	pfa_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending_results(pending_results),
		.results_checked(results_checked)
	);

	function automatic pfa_pkg::req_t make_req(logic [1:0] op, logic [7:0] tag,
			logic [11:0] size, logic [5:0] idx, logic [3:0] slot);
		pfa_pkg::req_t r;
		r.operation    = op;
		r.process_id   = tag;
		r.request_size = size;
		r.entry_index  = idx;
		r.frame_slot   = slot;
		return r;
	endfunction

	// offer one word; keep valid high across a burst, gap between bursts
	task automatic send_word(pfa_pkg::req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (r.operation != OP_UNUSED)
			words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	function automatic pfa_pkg::req_t random_req();
		int pick;
		logic [11:0] size;
		pick = $urandom_range(0, 99);
		size = $urandom_range(0, 9) == 0 ? 12'($urandom_range(0, 4095))
			: 12'($urandom_range(1, 80));
		if (pick < 38)
			return make_req(pfa_pkg::OP_ALLOC, 8'($urandom_range(1, 10)), size, '0, '0);
		if (pick < 62)
			return make_req(pfa_pkg::OP_FREE, 8'($urandom_range(1, 10)), 12'($urandom),
				'0, '0);
		if (pick < 90)
			return make_req(pfa_pkg::OP_READ, 8'($urandom), 12'($urandom),
				6'($urandom_range(0, 9)), 4'($urandom_range(0, 5)));
		if (pick < 93)
			return make_req(OP_UNUSED, 8'($urandom), 12'($urandom), 6'($urandom),
				4'($urandom));
		// noise over every field bit, with a valid operation code
		return make_req(2'($urandom_range(0, 2)), 8'($urandom), 12'($urandom),
			6'($urandom), 4'($urandom));
	endfunction

	// receiver: windows of varying stall density, plus requested long hold-offs
	initial begin
		int window;
		int density;
		forever begin
			if (holds_done != holds_asked) begin
				repeat (3000) begin
					@(posedge clk);
					out_ready <= 1'b0;
				end
				holds_done++;
			end else begin
				window  = $urandom_range(20, 200);
				density = $urandom_range(0, 2);
				repeat (window) begin
					@(posedge clk);
					case (density)
						0: out_ready <= 1'b1;
						1: out_ready <= $urandom_range(0, 1);
						default: out_ready <= $urandom_range(0, 4) == 0;
					endcase
				end
			end
		end
	end

	initial begin
		#(8 * 6_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		pfa_pkg::req_t directed [$];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		directed.push_back(make_req(pfa_pkg::OP_ALLOC, 8'd5,   12'd0,    6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_ALLOC, 8'd1,   12'd1,    6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_ALLOC, 8'd2,   12'd4095, 6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_ALLOC, 8'd3,   12'd16,   6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_ALLOC, 8'd3,   12'd17,   6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_ALLOC, 8'd4,   12'd200,  6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_READ,  8'd0,   12'd0,    6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_READ,  8'd0,   12'd0,    6'd2,  4'd1));
		directed.push_back(make_req(pfa_pkg::OP_READ,  8'd0,   12'd0,    6'd1,  4'd5));
		directed.push_back(make_req(pfa_pkg::OP_READ,  8'hff,  12'hfff,  6'd63, 4'd15));
		directed.push_back(make_req(pfa_pkg::OP_FREE,  8'd3,   12'd0,    6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_READ,  8'd0,   12'd0,    6'd1,  4'd1));
		directed.push_back(make_req(pfa_pkg::OP_FREE,  8'd200, 12'd0,    6'd0,  4'd0));
		directed.push_back(make_req(OP_UNUSED,         8'hff,  12'hfff,  6'd63, 4'd15));
		directed.push_back(make_req(pfa_pkg::OP_ALLOC, 8'd255, 12'd256,  6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_ALLOC, 8'd0,   12'd1,    6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_READ,  8'd0,   12'd0,    6'd3,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_FREE,  8'd0,   12'd0,    6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_FREE,  8'd1,   12'd0,    6'd0,  4'd0));
		directed.push_back(make_req(pfa_pkg::OP_FREE,  8'd255, 12'd0,    6'd0,  4'd0));
		foreach (directed[i]) send_word(directed[i]);
		drain_results();

		while (words_sent < 420) begin
			if (words_sent == 100)
				holds_asked++;
			if (words_sent == 300)
				drain_results();
			if (words_sent >= 180 && !full_seq_done) begin
				// free one entry for each random tag, fill the table with tag-zero entries
				// past its size, read across it, then release them again
				for (int t = 1; t <= 10; t++)
					send_word(make_req(pfa_pkg::OP_FREE, 8'(t), '0, '0, '0));
				for (int k = 0; k < 70; k++)
					send_word(make_req(pfa_pkg::OP_ALLOC, 8'd0,
						12'($urandom_range(1, 40)), '0, '0));
				for (int k = 0; k < 8; k++)
					send_word(make_req(pfa_pkg::OP_READ, '0, '0,
						6'($urandom_range(0, 63)), 4'($urandom_range(0, 3))));
				for (int k = 0; k < 66; k++)
					send_word(make_req(pfa_pkg::OP_FREE, 8'd0, '0, '0, '0));
				full_seq_done = 1;
			end else begin
				send_word(random_req());
			end
		end
		drain_results();
		repeat (2000) @(posedge clk);

		$display("run covered %0d requests and %0d result words, with a full table,",
			words_sent, results_checked);
		$display("rollbacks, bad indexes, a long receiver hold-off and bursty input");
		if (fail_count == 0 && pending_results == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
